// ----- rtl/stuffed_frame_encoder_reply_parser_top_assert.svh -----
// Assertion macros for the reply parser. Every property is clocked on clk
// and held off while rst_n is low.
`ifndef STUFFED_FRAME_ENCODER_REPLY_PARSER_TOP_ASSERT_SVH
`define STUFFED_FRAME_ENCODER_REPLY_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sfe_pkg.sv -----
package sfe_pkg;

  // Frame rules.
  localparam logic [7:0] MIN_FRAME_LENGTH   = 8'd13;
  localparam logic [7:0] PAYLOAD_LENGTH     = 8'd8;
  localparam logic [7:0] RESPONSE_FLAG_MASK = 8'h01;
  localparam logic [7:0] TARGET_FLAG_MASK   = 8'h10;
  localparam logic [7:0] SOURCE_FLAG_MASK   = 8'h20;
  localparam logic [7:0] LENGTH_MAX         = 8'hFF;

  // Register reset values.
  localparam logic [7:0] START_CODE_RST     = 8'd141;
  localparam logic [7:0] END_CODE_RST       = 8'd216;
  localparam logic [7:0] ESCAPE_CODE_RST    = 8'd171;
  localparam logic [7:0] ESC_ESCAPE_RST     = 8'd35;
  localparam logic [7:0] ESC_START_RST      = 8'd5;
  localparam logic [7:0] ESC_END_RST        = 8'd80;
  localparam logic [7:0] DEVICE_ID_RST      = 8'd24;
  localparam logic [7:0] COMMAND_ID_RST     = 8'd57;

  localparam int unsigned PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_START_CODE     = 3'd0,
    REG_END_CODE       = 3'd1,
    REG_ESCAPE_CODE    = 3'd2,
    REG_ESC_ESCAPE     = 3'd3,
    REG_ESC_START      = 3'd4,
    REG_ESC_END        = 3'd5,
    REG_DEVICE_ID      = 3'd6,
    REG_COMMAND_ID     = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    VERDICT_OK            = 3'd0,
    VERDICT_TOO_SHORT     = 3'd1,
    VERDICT_BAD_CHECKSUM  = 3'd2,
    VERDICT_NOT_RESPONSE  = 3'd3,
    VERDICT_WRONG_IDS     = 3'd4,
    VERDICT_SHORT_PAYLOAD = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] esc_escape;
    logic [7:0] esc_start;
    logic [7:0] esc_end;
    logic [7:0] device_id;
    logic [7:0] command_id;
  } cfg_t;

  typedef struct packed {
    logic               valid;
    verdict_t           verdict;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
  } res_t;

endpackage

// ----- rtl/stuffed_frame_encoder_reply_parser_top.sv -----
// Reply parser for byte-stuffed motor controller frames. Each input request
// carries one received link byte; the block takes one byte per clock cycle
// while the skid entry is free and keeps running state (frame length, byte
// sum, header fields, payload) instead of a frame buffer. A start byte opens
// a frame only while idle, an escape byte plus a known code gives a literal
// byte, and an escape plus an unknown code drops the frame silently. An
// unescaped end byte closes the frame; a non-empty frame produces exactly one
// result request through the result register, carrying the verdict and, when
// the verdict is OK, the two big-endian signed encoder counts (zero
// otherwise). Results sit in an output register backed by one skid entry, so
// the input keeps flowing while a result waits; in_ready drops only when both
// are full. The eight 8-bit framing and id registers sit at byte addresses 0
// to 28 of the APB-style port, which has no wait states; they should be
// written only while no frame is in progress.
module stuffed_frame_encoder_reply_parser_top (
  input  logic                         clk,
  input  logic                         rst_n,
  // Received bytes.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_rx_byte,
  // Frame results.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   out_verdict,
  output logic signed [31:0]           out_left_count,
  output logic signed [31:0]           out_right_count,
  // Register port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfe_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  `include "stuffed_frame_encoder_reply_parser_top_assert.svh"

  sfe_pkg::cfg_t cfg;
  sfe_pkg::res_t res;
  logic          accept;
  logic          out_free;
  logic          res_new;

  // The result register and the skid entry behind it.
  logic          out_valid_r, out_valid_nxt;
  sfe_pkg::res_t out_r, out_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  sfe_pkg::res_t skid_r, skid_nxt;

  sfe_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfe_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (accept),
    .rx_byte (in_rx_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // Bytes are taken as long as the skid entry is free, so a single waiting
  // result never stalls the link.
  assign in_ready = !skid_valid_r;
  assign accept   = in_valid & in_ready;
  assign res_new  = accept & res.valid;
  // The result register can be loaded when it is empty or being drained.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      // No byte is accepted in this cycle; drain the skid entry when possible.
      if (out_free) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_new) begin
      if (out_free) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_verdict     = out_r.verdict;
  assign out_left_count  = out_r.left_count;
  assign out_right_count = out_r.right_count;

  // The skid entry is only ever filled behind a full result register.
  `SFE_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r,
    "skid entry holds a result while the result register is empty")

  // A failed frame never reports counts.
  `SFE_ASSERT_SAME(a_fail_zero_counts,
    out_valid_r && out_verdict != sfe_pkg::VERDICT_OK,
    out_left_count == 32'sd0 && out_right_count == 32'sd0,
    "counts are nonzero on a failed verdict")

  // A result that meets a stalled output must land in the skid entry.
  `SFE_ASSERT_NEXT(a_stall_to_skid,
    accept && res.valid && out_valid_r && !out_ready,
    skid_valid_r,
    "result lost while the output was stalled")

  // Once the output drains, the skid entry moves into the result register in the next cycle.
  `SFE_ASSERT_NEXT(a_skid_drains, skid_valid_r && out_ready,
    out_valid_r && !skid_valid_r,
    "skid entry did not move into the result register")

endmodule

// ----- rtl/sfe_regs.sv -----
module sfe_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfe_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output sfe_pkg::cfg_t                cfg
);

  sfe_pkg::cfg_t    cfg_r;
  sfe_pkg::cfg_t    cfg_nxt;
  sfe_pkg::reg_idx_t idx;
  logic             wr_en;
  logic [7:0]       rd_val;

  assign idx   = sfe_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg   = cfg_r;
  assign prdata = {24'd0, rd_val};

  always_comb begin
    cfg_nxt = cfg_r;
    rd_val  = 8'd0;
    case (idx)
      sfe_pkg::REG_START_CODE: begin
        rd_val = cfg_r.start_code;
        if (wr_en) cfg_nxt.start_code = pwdata[7:0];
      end
      sfe_pkg::REG_END_CODE: begin
        rd_val = cfg_r.end_code;
        if (wr_en) cfg_nxt.end_code = pwdata[7:0];
      end
      sfe_pkg::REG_ESCAPE_CODE: begin
        rd_val = cfg_r.escape_code;
        if (wr_en) cfg_nxt.escape_code = pwdata[7:0];
      end
      sfe_pkg::REG_ESC_ESCAPE: begin
        rd_val = cfg_r.esc_escape;
        if (wr_en) cfg_nxt.esc_escape = pwdata[7:0];
      end
      sfe_pkg::REG_ESC_START: begin
        rd_val = cfg_r.esc_start;
        if (wr_en) cfg_nxt.esc_start = pwdata[7:0];
      end
      sfe_pkg::REG_ESC_END: begin
        rd_val = cfg_r.esc_end;
        if (wr_en) cfg_nxt.esc_end = pwdata[7:0];
      end
      sfe_pkg::REG_DEVICE_ID: begin
        rd_val = cfg_r.device_id;
        if (wr_en) cfg_nxt.device_id = pwdata[7:0];
      end
      sfe_pkg::REG_COMMAND_ID: begin
        rd_val = cfg_r.command_id;
        if (wr_en) cfg_nxt.command_id = pwdata[7:0];
      end
      default: begin
        rd_val = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code  <= sfe_pkg::START_CODE_RST;
      cfg_r.end_code    <= sfe_pkg::END_CODE_RST;
      cfg_r.escape_code <= sfe_pkg::ESCAPE_CODE_RST;
      cfg_r.esc_escape  <= sfe_pkg::ESC_ESCAPE_RST;
      cfg_r.esc_start   <= sfe_pkg::ESC_START_RST;
      cfg_r.esc_end     <= sfe_pkg::ESC_END_RST;
      cfg_r.device_id   <= sfe_pkg::DEVICE_ID_RST;
      cfg_r.command_id  <= sfe_pkg::COMMAND_ID_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/sfe_core.sv -----
module sfe_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  logic [7:0]    rx_byte,
  input  sfe_pkg::cfg_t cfg,
  output sfe_pkg::res_t res
);

  logic        inside_r, inside_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  dev_r, dev_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [63:0] pay_r, pay_nxt;

  logic        clear;
  logic        data_en;
  logic [7:0]  data_byte;
  logic [7:0]  flags_new;
  logic [7:0]  hdr_new;
  logic [7:0]  hdr_cur;
  logic [7:0]  body_sum;
  logic        res_valid;
  sfe_pkg::verdict_t verdict;

  // Framing and escape decode.
  always_comb begin
    inside_nxt = inside_r;
    esc_nxt    = esc_r;
    clear      = 1'b0;
    data_en    = 1'b0;
    data_byte  = rx_byte;
    res_valid  = 1'b0;
    if (!inside_r) begin
      if (rx_byte == cfg.start_code) begin
        clear      = 1'b1;
        inside_nxt = 1'b1;
        esc_nxt    = 1'b0;
      end
    end else if (rx_byte == cfg.end_code && !esc_r) begin
      res_valid  = (len_r != 8'd0);
      inside_nxt = 1'b0;
      esc_nxt    = 1'b0;
      clear      = 1'b1;
    end else if (rx_byte == cfg.escape_code && !esc_r) begin
      esc_nxt = 1'b1;
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      if (rx_byte == cfg.esc_escape) begin
        data_en   = 1'b1;
        data_byte = cfg.escape_code;
      end else if (rx_byte == cfg.esc_start) begin
        data_en   = 1'b1;
        data_byte = cfg.start_code;
      end else if (rx_byte == cfg.esc_end) begin
        data_en   = 1'b1;
        data_byte = cfg.end_code;
      end else begin
        inside_nxt = 1'b0;
        clear      = 1'b1;
      end
    end else begin
      data_en = 1'b1;
    end
  end

  // Field capture for one data byte, placed by its position in the frame.
  assign flags_new = (len_r == 8'd0) ? data_byte : flags_r;
  assign hdr_new = 8'd1
                 + {7'd0, |(flags_new & sfe_pkg::TARGET_FLAG_MASK)}
                 + {7'd0, |(flags_new & sfe_pkg::SOURCE_FLAG_MASK)};

  always_comb begin
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    prev_nxt  = prev_r;
    flags_nxt = flags_r;
    dev_nxt   = dev_r;
    cmd_nxt   = cmd_r;
    pay_nxt   = pay_r;
    if (clear) begin
      len_nxt   = 8'd0;
      sum_nxt   = 8'd0;
      prev_nxt  = 8'd0;
      flags_nxt = 8'd0;
      dev_nxt   = 8'd0;
      cmd_nxt   = 8'd0;
      pay_nxt   = 64'd0;
    end else if (data_en) begin
      flags_nxt = flags_new;
      if (len_r == hdr_new) dev_nxt = data_byte;
      if (len_r == hdr_new + 8'd1) cmd_nxt = data_byte;
      if (len_r >= hdr_new + 8'd4 &&
          len_r < hdr_new + 8'd4 + sfe_pkg::PAYLOAD_LENGTH) begin
        pay_nxt = {pay_r[55:0], data_byte};
      end
      sum_nxt  = sum_r + data_byte;
      prev_nxt = data_byte;
      if (len_r != sfe_pkg::LENGTH_MAX) len_nxt = len_r + 8'd1;
    end
  end

  // Verdict, from the state as it stands when the end byte arrives.
  assign hdr_cur = 8'd1
                 + {7'd0, |(flags_r & sfe_pkg::TARGET_FLAG_MASK)}
                 + {7'd0, |(flags_r & sfe_pkg::SOURCE_FLAG_MASK)};
  assign body_sum = sum_r - prev_r;

  always_comb begin
    if (len_r < sfe_pkg::MIN_FRAME_LENGTH) begin
      verdict = sfe_pkg::VERDICT_TOO_SHORT;
    end else if (~body_sum != prev_r) begin
      verdict = sfe_pkg::VERDICT_BAD_CHECKSUM;
    end else if ((flags_r & sfe_pkg::RESPONSE_FLAG_MASK) == 8'd0) begin
      verdict = sfe_pkg::VERDICT_NOT_RESPONSE;
    end else if (hdr_cur + 8'd3 >= len_r) begin
      verdict = sfe_pkg::VERDICT_TOO_SHORT;
    end else if (dev_r != cfg.device_id || cmd_r != cfg.command_id) begin
      verdict = sfe_pkg::VERDICT_WRONG_IDS;
    end else if (len_r < hdr_cur + 8'd5 + sfe_pkg::PAYLOAD_LENGTH) begin
      verdict = sfe_pkg::VERDICT_SHORT_PAYLOAD;
    end else begin
      verdict = sfe_pkg::VERDICT_OK;
    end
  end

  assign res = '{
    valid:       res_valid,
    verdict:     verdict,
    left_count:  (verdict == sfe_pkg::VERDICT_OK) ? pay_r[63:32] : 32'sd0,
    right_count: (verdict == sfe_pkg::VERDICT_OK) ? pay_r[31:0] : 32'sd0
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      esc_r    <= 1'b0;
    end else if (take) begin
      inside_r <= inside_nxt;
      esc_r    <= esc_nxt;
    end
  end

  // Frame fields are cleared by the start byte before they are used.
  always_ff @(posedge clk) begin
    if (take) begin
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      prev_r  <= prev_nxt;
      flags_r <= flags_nxt;
      dev_r   <= dev_nxt;
      cmd_r   <= cmd_nxt;
      pay_r   <= pay_nxt;
    end
  end

endmodule
